/* src/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - PRIO_W - OCC_W;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occ;
  } result_t;

endpackage

/* src/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  spq_pkg::entry_t    new_i,
  input  logic               occupied_i,
  input  logic               head_i,
  input  logic               left_keep_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output logic               keep_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // head keeps its slot on equal priority, other cells yield to the newcomer
  assign keep_o = occupied_i &&
                  ((entry_q.prio > new_i.prio) ||
                   (head_i && (entry_q.prio == new_i.prio)));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.enq) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? new_i : left_i;
      end
    end else if (ctl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* src/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// a result is registered and is on the master side in the cycle after its request is accepted
// throughput: one transaction per cycle while the result is not stalled; every cell compares
//   against the new entry in parallel and shifts by one place, so the whole chain updates at once
// reset: rst_ni clears the entry count and the output valid; cell contents stay
//   undefined and are never read at or beyond the count

module sorted_priority_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] item_value, [39:32] item_priority
  input  logic [spq_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [spq_pkg::OP_W-1:0]       s_axis_tuser_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] head_value, [39:32] head_priority, [44:40] occupancy, rest zero
  output logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [spq_pkg::STATUS_W-1:0]   m_axis_tuser_o
);
  import spq_pkg::*;

  // request decode
  logic            accept;
  logic [OP_W-1:0] op;
  entry_t          new_entry;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = s_axis_tuser_i;
  assign new_entry.value = s_axis_tdata_i[VALUE_W-1:0];
  assign new_entry.prio  = s_axis_tdata_i[VALUE_W+PRIO_W-1:VALUE_W];

  // entry count
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             full;
  logic             empty;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  cell_ctl_t ctl;
  assign ctl.enq = accept && (op == OP_ENQUEUE) && !full;
  assign ctl.deq = accept && (op == OP_DEQUEUE) && !empty;

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell chain, head at index zero
  entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_keep;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occupied;
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    assign occupied = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      // nothing ahead of the head, so a displaced head always takes the new entry
      assign left_keep  = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_i       (new_entry),
      .occupied_i  (occupied),
      .head_i      (i == 0),
      .left_keep_i (left_keep),
      .left_i      (left_entry),
      .right_i     (right_entry),
      .entry_o     (cell_entry[i]),
      .keep_o      (cell_keep[i])
    );
  end

  // result for the accepted request, based on state before the update; occupancy counts the update
  result_t res_d;
  result_t res_q;

  always_comb begin
    res_d.value  = '0;
    res_d.prio   = '0;
    res_d.status = ST_OK;
    res_d.occ    = OCC_W'(count_d);
    case (op)
      OP_ENQUEUE: begin
        res_d.status = full ? ST_FULL : ST_OK;
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (empty) begin
          res_d.value  = EMPTY_VALUE;
          res_d.status = ST_EMPTY;
        end else begin
          res_d.value = cell_entry[0].value;
          res_d.prio  = cell_entry[0].prio;
        end
      end
      default: begin
        // unused code, no operation
        res_d.status = ST_OK;
      end
    endcase
  end

  // output register; a new request is taken whenever the slot is empty or frees this cycle
  logic m_valid_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, res_q.occ, res_q.prio, res_q.value};
  assign m_axis_tuser_o  = res_q.status;

  // checks
  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      count_q <= CNT_W'(CAPACITY);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("entry count above capacity");

  property p_full_reject;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && (op == OP_ENQUEUE) && full) |=> $stable(count_q);
  endproperty
  a_full_reject: assert property (p_full_reject)
    else $error("rejected enqueue changed the entry count");

  property p_stall_blocks;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o;
  endproperty
  a_stall_blocks: assert property (p_stall_blocks)
    else $error("request taken while result is stalled");

  property p_head_order;
    @(posedge clk_i) disable iff (!rst_ni)
      (count_q >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio);
  endproperty
  a_head_order: assert property (p_head_order)
    else $error("head priority below its successor");

endmodule

/* tb/sorted_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  // the block treats the spare operation code as a no-op
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    bit                        drain_first;  // hold off until every result is back
  } request_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i;
  logic [OP_W-1:0]         s_axis_tuser_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic [STATUS_W-1:0]     m_axis_tuser_o;

  sorted_priority_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  request_t    pending_reqs[$];
  result_t     expected_results[$];

  // shadow copy of the sorted store, head at index 0
  entry_t      queue_shadow[CAPACITY];
  int unsigned shadow_count;

  int          total_reqs;
  int          reqs_accepted;
  int          mismatch_count;
  int          stall_cycles;
  logic        req_taken;

  int          n_enq, n_full, n_deq, n_peek, n_nop, n_empty, peak_occ;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // no idling on either side for a stretch in the middle of the run
  function automatic bit take_a_break();
    if (reqs_accepted >= 400 && reqs_accepted < 560) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return PRIO_W'($urandom_range(3));  // dense ties
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return PRIO_W'($urandom);
  endfunction

  function automatic void add_req(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                                  logic [PRIO_W-1:0] prio, bit drain_first);
    request_t r;
    r.op          = op;
    r.value       = value;
    r.prio        = prio;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endfunction

  // applies one request to the shadow queue and returns the result it must produce
  function automatic result_t apply_request(logic [OP_W-1:0] op,
                                            logic signed [VALUE_W-1:0] value,
                                            logic [PRIO_W-1:0] prio);
    result_t res;
    int unsigned slot;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_ENQUEUE: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // a new entry only takes the head from a strictly lower priority
          if (shadow_count == 0 || queue_shadow[0].prio < prio) begin
            slot = 0;
          end else begin
            slot = 1;
            while (slot < shadow_count && queue_shadow[slot].prio > prio) slot++;
          end
          for (int unsigned k = shadow_count; k > slot; k--) queue_shadow[k] = queue_shadow[k-1];
          queue_shadow[slot].value = value;
          queue_shadow[slot].prio  = prio;
          shadow_count++;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (shadow_count == 0) begin
          res.value  = EMPTY_VALUE;
          res.status = ST_EMPTY;
        end else begin
          res.value = queue_shadow[0].value;
          res.prio  = queue_shadow[0].prio;
          if (op == OP_DEQUEUE) begin
            for (int unsigned k = 1; k < shadow_count; k++) queue_shadow[k-1] = queue_shadow[k];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.occ = OCC_W'(shadow_count);
    return res;
  endfunction

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // driver: presents the next request at the falling edge once the slot is free
  always @(negedge clk_i) begin : drive_proc
    request_t nxt;
    bit       send;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || req_taken) begin
        send = 1'b0;
        if (pending_reqs.size() != 0 && !take_a_break()) begin
          if (!pending_reqs[0].drain_first || expected_results.size() == 0) send = 1'b1;
        end
        if (send) begin
          nxt = pending_reqs.pop_front();
          s_axis_tdata_i <= {nxt.prio, nxt.value};
          s_axis_tuser_i <= nxt.op;
        end
        s_axis_tvalid_i <= send;
      end
      m_axis_tready_i <= !take_a_break();
    end
  end

  // monitor: checks each result transaction and predicts each accepted request
  always @(posedge clk_i) begin : monitor_proc
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result, expected none, actual tdata 0x%0h status %0d",
                   $time, m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          want = expected_results.pop_front();
          report_field("head_value", 64'(unsigned'(want.value)), 64'(m_axis_tdata_o[31:0]));
          report_field("head_priority", 64'(want.prio), 64'(m_axis_tdata_o[39:32]));
          report_field("occupancy", 64'(want.occ), 64'(m_axis_tdata_o[44:40]));
          report_field("padding", 64'd0, 64'(m_axis_tdata_o[OUT_TDATA_W-1:45]));
          report_field("status", 64'(want.status), 64'(m_axis_tuser_o));
        end
      end
      req_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pred = apply_request(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[39:32]);
        expected_results.push_back(pred);
        reqs_accepted++;
        case (s_axis_tuser_i)
          OP_ENQUEUE: n_enq++;
          OP_DEQUEUE: n_deq++;
          OP_PEEK:    n_peek++;
          default:    n_nop++;
        endcase
        if (pred.status == ST_FULL) n_full++;
        if (pred.status == ST_EMPTY) n_empty++;
        if (pred.occ > peak_occ) peak_occ = pred.occ;
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  // watchdog: ends the run if no transaction moves for too long
  always @(posedge clk_i) begin : watchdog_proc
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("** sorted_priority_queue_top: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0] op;
    int              roll;
    bit              fill;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    req_taken       = 1'b0;
    shadow_count    = 0;
    reqs_accepted   = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    {n_enq, n_full, n_deq, n_peek, n_nop, n_empty, peak_occ} = '0;

    // directed: empty reads, no-op, extreme fields, tie handling at and behind the head
    add_req(OP_PEEK,    32'sh5a5a5a5a, 8'hff, 1'b0);
    add_req(OP_DEQUEUE, 32'sh0,        8'h00, 1'b0);
    add_req(OP_NOP,     32'sh7fffffff, 8'hff, 1'b0);
    add_req(OP_ENQUEUE, 32'sh7fffffff, 8'd0,  1'b0);
    add_req(OP_ENQUEUE, 32'sh80000000, 8'd0,  1'b0);
    add_req(OP_ENQUEUE, 32'sh0,        8'd255, 1'b0);
    add_req(OP_ENQUEUE, -32'sd1,       8'd255, 1'b0);
    add_req(OP_ENQUEUE, 32'sd5,        8'd0,  1'b0);
    add_req(OP_ENQUEUE, 32'sd7,        8'd128, 1'b0);
    add_req(OP_PEEK,    32'sh0,        8'h00, 1'b0);
    add_req(OP_NOP,     32'sh12345678, 8'h5a, 1'b0);
    for (int i = 0; i < 6; i++) add_req(OP_DEQUEUE, $urandom, pick_prio(), 1'b0);
    add_req(OP_DEQUEUE, 32'sh0,        8'h00, 1'b0);
    add_req(OP_PEEK,    32'sh0,        8'h00, 1'b0);

    // random: alternate filling and draining phases so full and empty are both hit
    for (int seg = 0; seg < 15; seg++) begin
      fill = (seg % 2 == 0);
      for (int i = 0; i < 62; i++) begin
        roll = $urandom_range(99);
        if (roll < (fill ? 65 : 30)) op = OP_ENQUEUE;
        else if (roll < (fill ? 85 : 80)) op = OP_DEQUEUE;
        else if (roll < 97) op = OP_PEEK;
        else op = OP_NOP;
        roll = $urandom_range(99);
        add_req(op, (roll < 5) ? 32'sh7fffffff : (roll < 10) ? 32'sh80000000 : $urandom,
                pick_prio(), (seg % 5 == 4) && (i == 0));
      end
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (reqs_accepted < total_reqs) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("run covered %0d requests: %0d enqueues (%0d refused as full), %0d dequeues,",
             reqs_accepted, n_enq, n_full, n_deq);
    $display("  %0d peeks, %0d no-ops, %0d reads of an empty queue, peak occupancy %0d",
             n_peek, n_nop, n_empty, peak_occ);
    if (mismatch_count == 0) begin
      $display("** sorted_priority_queue_top: PASSED **");
    end else begin
      $display("** sorted_priority_queue_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sorted_priority_queue_top.f */
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_tb.sv
